FILE: src/ets_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ets_pkg
// Shared constants and word types of the exponential series unit.
// ----------------------------------------------------------------------------
package ets_pkg;

  // Field widths
  localparam int X_W   = 16;
  localparam int MAG_W = 16;
  localparam int OUT_W = 32;

  // Extra fraction bits carried by the terms and the running sum
  localparam int GUARD_BITS = 14;

  // Ceiling of terms and sum: 2^32 output units in the working format
  localparam int CEIL_EXP = OUT_W + GUARD_BITS;
  localparam int TERM_W   = CEIL_EXP + 1;
  localparam logic [TERM_W-1:0] SUM_CEIL = {1'b1, {CEIL_EXP{1'b0}}};

  // Word handed from one series cell to the next
  typedef struct packed {
    logic              pos;
    logic              clamped;
    logic [MAG_W-1:0]  mag;
    logic [TERM_W-1:0] term;
    logic [TERM_W-1:0] sum;
  } ets_series_t;

  // Status that rides along the divider chain
  typedef struct packed {
    logic             pos;
    logic             sat;
    logic [OUT_W-1:0] pos_res;
  } ets_side_t;

endpackage

FILE: src/ets_x_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ets_x_if
// Argument channel: valid/ready handshake carrying one signed argument word.
// ----------------------------------------------------------------------------
interface ets_x_if import ets_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic signed [X_W-1:0] x_value;

  modport source (output valid, output x_value, input ready);
  modport sink   (input valid, input x_value, output ready);
endinterface

FILE: src/ets_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ets_res_if
// Result channel: valid/ready handshake carrying e^x and its saturation flag.
// ----------------------------------------------------------------------------
interface ets_res_if import ets_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] exp_result;
  logic             saturated;

  modport source (output valid, output exp_result, output saturated, input ready);
  modport sink   (input valid, input exp_result, input saturated, output ready);
endinterface

FILE: src/ets_term_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ets_term_cell
// One series cell: term_k = floor(term_(k-1) * a / (K * 2^IN_FRAC_BITS)),
// clamp, accumulate. Five register stages; division by the odd part of K
// runs as two reciprocal multiplies on the high and low halves.
// ----------------------------------------------------------------------------
module ets_term_cell import ets_pkg::*; #(
  parameter int unsigned K            = 1,
  parameter int unsigned IN_FRAC_BITS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  ets_series_t ser_i,
  output logic        valid_o,
  output ets_series_t ser_o
);

  function automatic int ctz5(int unsigned v);
    int n;
    bit stop;
    n    = 0;
    stop = 1'b0;
    for (int i = 0; i < 5; i++) begin
      if (!stop) begin
        if (v[i]) begin
          stop = 1'b1;
        end else begin
          n = n + 1;
        end
      end
    end
    return n;
  endfunction

  localparam int TZ     = ctz5(K);
  localparam int D      = K >> TZ;
  localparam int C      = $clog2(D);
  localparam int PROD_W = TERM_W + MAG_W;
  localparam int SH     = IN_FRAC_BITS + TZ;
  localparam int NW     = PROD_W - SH;
  localparam int LW     = NW / 2;
  localparam int HW     = NW - LW;
  localparam int RW     = (C > 0) ? C : 1;
  localparam int X2_W   = LW + C;

  localparam int S1   = HW + C;
  localparam int M1_W = HW + 1;
  localparam int P1_W = S1 + HW;
  localparam logic [63:0] M1_64 = ((64'd1 << S1) + 64'(D) - 64'd1) / 64'(D);
  localparam logic [M1_W-1:0] M1 = M1_64[M1_W-1:0];

  localparam int S2   = X2_W + C;
  localparam int M2_W = X2_W + 1;
  localparam int P2_W = S2 + LW;
  localparam logic [63:0] M2_64 = ((64'd1 << S2) + 64'(D) - 64'd1) / 64'(D);
  localparam logic [M2_W-1:0] M2 = M2_64[M2_W-1:0];

  // Stage A: product
  logic              va_q;
  ets_series_t       sa_q;
  logic [PROD_W-1:0] pa_d, pa_q;

  // Stage B: high quotient
  logic              vb_q;
  ets_series_t       sb_q;
  logic [NW-1:0]     n_b;
  logic [P1_W-1:0]   prod1;
  logic [HW-1:0]     qh_b_d, qh_b_q, nh_b_q;
  logic [LW-1:0]     nl_b_q;

  // Stage C: remainder joins the low half
  logic              vc_q;
  ets_series_t       sc_q;
  logic [HW-1:0]     rh_full;
  logic [RW-1:0]     rh;
  logic [X2_W-1:0]   x2_d, x2_q;
  logic [HW-1:0]     qh_c_q;

  // Stage D: low quotient
  logic              vd_q;
  ets_series_t       sd_q;
  logic [P2_W-1:0]   prod2;
  logic [LW-1:0]     ql_d, ql_q;
  logic [HW-1:0]     qh_d_q;

  // Stage E: clamp and accumulate
  logic [NW-1:0]     q_e;
  logic [63:0]       q64;
  logic [TERM_W-1:0] term_e;
  logic [TERM_W:0]   sum_w;
  ets_series_t       ser_d, ser_q;
  logic              ve_q;

  assign pa_d = {{MAG_W{1'b0}}, ser_i.term} * {{TERM_W{1'b0}}, ser_i.mag};

  assign n_b    = pa_q[PROD_W-1:SH];
  assign prod1  = P1_W'(n_b[NW-1:LW]) * P1_W'(M1);
  assign qh_b_d = prod1[P1_W-1:S1];

  assign rh_full = nh_b_q - qh_b_q * HW'(D);
  assign rh      = rh_full[RW-1:0];
  assign x2_d    = (X2_W'(rh) << LW) | X2_W'(nl_b_q);

  assign prod2 = P2_W'(x2_q) * P2_W'(M2);
  assign ql_d  = prod2[P2_W-1:S2];

  assign q_e    = {qh_d_q, ql_q};
  assign q64    = 64'(q_e);
  assign term_e = (q64 > 64'(SUM_CEIL)) ? SUM_CEIL : q64[TERM_W-1:0];
  assign sum_w  = {1'b0, sd_q.sum} + {1'b0, term_e};

  always_comb begin
    ser_d      = sd_q;
    ser_d.term = term_e;
    if (sum_w >= {1'b0, SUM_CEIL}) begin
      ser_d.sum     = SUM_CEIL;
      ser_d.clamped = 1'b1;
    end else begin
      ser_d.sum = sum_w[TERM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
      ve_q <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sa_q   <= ser_i;
      pa_q   <= pa_d;
      sb_q   <= sa_q;
      qh_b_q <= qh_b_d;
      nh_b_q <= n_b[NW-1:LW];
      nl_b_q <= n_b[LW-1:0];
      sc_q   <= sb_q;
      qh_c_q <= qh_b_q;
      x2_q   <= x2_d;
      sd_q   <= sc_q;
      qh_d_q <= qh_c_q;
      ql_q   <= ql_d;
      ser_q  <= ser_d;
    end
  end

  assign valid_o = ve_q;
  assign ser_o   = ser_q;

  // Once the sum hits the ceiling it stays there, so the flag tracks it
  a_clamp_tracks_ceiling: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (ser_o.clamped == (ser_o.sum == SUM_CEIL)))
    else $error("clamp flag out of step with sum");

  a_sum_covers_term: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (ser_o.term <= SUM_CEIL) && (ser_o.sum >= ser_o.term))
    else $error("term above ceiling or sum below term");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(valid_o))
    else $error("cell advanced while stalled");

endmodule

FILE: src/ets_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ets_div_cell
// One restoring-division cell: shift in a numerator bit, compare, subtract,
// emit one quotient bit.
// ----------------------------------------------------------------------------
module ets_div_cell import ets_pkg::*; #(
  parameter int unsigned QB = 17
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [TERM_W-1:0] r_i,
  input  logic [TERM_W-1:0] d_i,
  input  logic [QB-1:0]     nb_i,
  input  logic [QB-1:0]     q_i,
  input  ets_side_t         side_i,
  output logic              valid_o,
  output logic [TERM_W-1:0] r_o,
  output logic [TERM_W-1:0] d_o,
  output logic [QB-1:0]     nb_o,
  output logic [QB-1:0]     q_o,
  output ets_side_t         side_o
);

  logic [TERM_W:0]   rs;
  logic              ge;
  logic [TERM_W:0]   r_n;
  logic              valid_q;
  logic [TERM_W-1:0] r_q, d_q;
  logic [QB-1:0]     nb_q, q_q;
  ets_side_t         side_q;

  assign rs  = {r_i, nb_i[QB-1]};
  assign ge  = (rs >= {1'b0, d_i});
  assign r_n = ge ? (rs - {1'b0, d_i}) : rs;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q    <= r_n[TERM_W-1:0];
      d_q    <= d_i;
      nb_q   <= {nb_i[QB-2:0], 1'b0};
      q_q    <= {q_i[QB-2:0], ge};
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign r_o     = r_q;
  assign d_o     = d_q;
  assign nb_o    = nb_q;
  assign q_o     = q_q;
  assign side_o  = side_q;

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (r_o < d_o))
    else $error("partial remainder not below divisor");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (d_o != '0))
    else $error("zero divisor in chain");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(valid_o) && $stable(q_o))
    else $error("divider cell advanced while stalled");

endmodule

FILE: src/exp_taylor_series_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exp_taylor_series_unit
// Pipelined e^x by a truncated Taylor series over |x|, with reciprocal for
// zero and negative arguments.
// ----------------------------------------------------------------------------
// Takes one Q3.12 argument word per cycle and returns one unsigned Q16.16
// result word per argument, in order. The series 1 + sum a^k/k! (a = |x|)
// is built by a chain of TERMS cells, five register stages each; a positive
// argument returns the sum shifted down to the output format, clamped at the
// maximum with saturated set. Zero and negative arguments return 1/S rounded
// to nearest, computed by a chain of OUT_FRAC_BITS + 1 restoring-division
// cells, one quotient bit per cell. A word passes the term cells, a divider
// set-up register, the division cells and an output register. The whole
// pipeline holds only when a finished word sits in the last divider cell
// and the output register is full and not being taken.
// ----------------------------------------------------------------------------
module exp_taylor_series_unit import ets_pkg::*; #(
  parameter int unsigned TERMS         = 10,
  parameter int unsigned IN_FRAC_BITS  = 12,
  parameter int unsigned OUT_FRAC_BITS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  ets_x_if.sink    x_i,
  ets_res_if.source res_o
);

  localparam int WF      = OUT_FRAC_BITS + GUARD_BITS;
  localparam int QB      = OUT_FRAC_BITS + 1;
  localparam int NUM_EXP = 2 * OUT_FRAC_BITS + GUARD_BITS;
  localparam int NUM_W   = ((NUM_EXP > CEIL_EXP) ? NUM_EXP : CEIL_EXP) + 1;
  localparam int SH_W    = TERM_W - GUARD_BITS;

  localparam logic [TERM_W-1:0] ONE_W    = TERM_W'(64'd1 << WF);
  localparam logic [NUM_W-1:0]  NUM_BASE = NUM_W'(64'd1 << NUM_EXP);

  logic adv;

  // Argument decode
  logic [MAG_W-1:0] raw_u;
  logic             neg;
  logic [MAG_W-1:0] mag;

  // Series chain
  logic        cv  [TERMS+1];
  ets_series_t ser [TERMS+1];

  // Divider set-up
  ets_series_t       s_last;
  logic [NUM_W-1:0]  num_d;
  logic [SH_W-1:0]   s_shift;
  logic              over;
  ets_side_t         side_d;
  logic              vp_q;
  logic [TERM_W-1:0] rp_q, dp_q;
  logic [QB-1:0]     nbp_q;
  ets_side_t         sidep_q;

  // Divider chain
  logic              dv    [QB+1];
  logic [TERM_W-1:0] dr    [QB+1];
  logic [TERM_W-1:0] dd    [QB+1];
  logic [QB-1:0]     dnb   [QB+1];
  logic [QB-1:0]     dq    [QB+1];
  ets_side_t         dside [QB+1];

  // Output register
  logic             out_valid_q;
  logic [OUT_W-1:0] res_d, res_q;
  logic             sat_q;

  // Stall only when a finished word cannot move into the output register
  assign adv       = !(dv[QB] && out_valid_q && !res_o.ready);
  assign x_i.ready = adv;

  // Take the magnitude; the most negative argument maps to 0x8000
  assign raw_u = x_i.x_value;
  assign neg   = raw_u[MAG_W-1];
  assign mag   = neg ? (~raw_u + MAG_W'(1)) : raw_u;

  assign cv[0]          = x_i.valid;
  assign ser[0].pos     = !neg && (raw_u != '0);
  assign ser[0].clamped = 1'b0;
  assign ser[0].mag     = mag;
  assign ser[0].term    = ONE_W;
  assign ser[0].sum     = ONE_W;

  for (genvar g = 0; g < TERMS; g++) begin : g_term
    ets_term_cell #(
      .K            (g + 1),
      .IN_FRAC_BITS (IN_FRAC_BITS)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (cv[g]),
      .ser_i   (ser[g]),
      .valid_o (cv[g+1]),
      .ser_o   (ser[g+1])
    );
  end

  // Build numerator 2^(2F+G) + S/2 for the rounded reciprocal, and the
  // positive-path result, which is the sum with the guard bits dropped
  assign s_last  = ser[TERMS];
  assign num_d   = NUM_BASE + NUM_W'(s_last.sum >> 1);
  assign s_shift = s_last.sum[TERM_W-1:GUARD_BITS];
  assign over    = s_shift[OUT_W];

  assign side_d.pos     = s_last.pos;
  assign side_d.sat     = s_last.clamped | (s_last.pos & over);
  assign side_d.pos_res = over ? '1 : s_shift[OUT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
    end else if (adv) begin
      vp_q <= cv[TERMS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rp_q    <= TERM_W'(num_d >> QB);
      dp_q    <= s_last.sum;
      nbp_q   <= num_d[QB-1:0];
      sidep_q <= side_d;
    end
  end

  assign dv[0]    = vp_q;
  assign dr[0]    = rp_q;
  assign dd[0]    = dp_q;
  assign dnb[0]   = nbp_q;
  assign dq[0]    = '0;
  assign dside[0] = sidep_q;

  for (genvar g = 0; g < QB; g++) begin : g_div
    ets_div_cell #(
      .QB (QB)
    ) u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (dv[g]),
      .r_i     (dr[g]),
      .d_i     (dd[g]),
      .nb_i    (dnb[g]),
      .q_i     (dq[g]),
      .side_i  (dside[g]),
      .valid_o (dv[g+1]),
      .r_o     (dr[g+1]),
      .d_o     (dd[g+1]),
      .nb_o    (dnb[g+1]),
      .q_o     (dq[g+1]),
      .side_o  (dside[g+1])
    );
  end

  // Pick the positive sum or the reciprocal quotient
  assign res_d = dside[QB].pos ? dside[QB].pos_res : OUT_W'(dq[QB]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_o.ready || !out_valid_q) begin
      out_valid_q <= dv[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_o.ready || !out_valid_q) begin
      res_q <= res_d;
      sat_q <= dside[QB].sat;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.exp_result = res_q;
  assign res_o.saturated  = sat_q;

  // Quotient must fit in QB bits: top of numerator below the divisor
  a_setup_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vp_q |-> (rp_q < dp_q) && (dp_q >= ONE_W))
    else $error("divider set-up out of range");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv[QB] |-> (dnb[QB] == '0) && (dr[QB] < dd[QB]))
    else $error("divider chain finished with bits left");

  a_stall_keeps_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> dv[QB])
    else $error("finished word dropped during stall");

endmodule
